// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg
// Types, codes and character classes for the FASTA record parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frp_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned OUT_W = 32;

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef enum logic [2:0] {
    K_NAME  = 3'd0,
    K_COPEN = 3'd1,
    K_CBYTE = 3'd2,
    K_SEQ   = 3'd3,
    K_END   = 3'd4,
    K_ERR   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    E_EMPTY_FILE  = 3'd0,
    E_NO_GT       = 3'd1,
    E_EXPECT_GT   = 3'd2,
    E_EOF_NAME    = 3'd3,
    E_EMPTY_NAME  = 3'd4,
    E_EOF_COMMENT = 3'd5,
    E_EMPTY_SEQ   = 3'd6
  } err_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    err_t              code;
    logic [OUT_W-1:0]  line;
    logic [OUT_W-1:0]  name_len;
    logic [OUT_W-1:0]  cmt_len;
    logic [OUT_W-1:0]  seq_len;
    logic              fin;
  } res_t;

  // tab, LF, VT, FF, CR, space
  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SP);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

// ===== hdl/fasta_record_parser_top.sv =====
// A result is registered in the output register, or in the skid entry when out_* is stalled.
// Throughput: one request per cycle while in_stall is low; the state update is a single pass.
// An output register plus one skid entry decouple the result side.
// Reset: synchronous, active low; parser restarts expecting the first '>',
// line count 1, all lengths 0, output and skid empty.
// ----------------------------------------------------------------------------
// fasta_record_parser_top
// Byte-serial FASTA parser tagging name, comment and sequence bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fasta_record_parser_top #(
  parameter int unsigned COUNT_WIDTH = frp_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_line_no,
  output logic [31:0] out_name_len,
  output logic [31:0] out_cmt_len,
  output logic [31:0] out_seq_len,
  output logic        out_finished
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned OW = frp_pkg::OUT_W;

  typedef enum logic [2:0] {
    PH_START, PH_NAME, PH_COMMENT, PH_SEQ_LEAD, PH_SEQ_WORD, PH_SEQ_GAP, PH_DONE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [CW-1:0]       nl_r, nl_nxt;
  logic [CW-1:0]       name_r, name_nxt;
  logic [CW-1:0]       cmt_r, cmt_nxt;
  logic [CW-1:0]       seq_r, seq_nxt;
  frp_pkg::res_t       res;
  logic                res_vld;
  frp_pkg::res_t       out_r, skid_r;
  logic                out_valid_r, skid_valid_r;
  logic                accept, out_free;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (x == {CW{1'b1}}) ? x : x + {{(CW-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [OW-1:0] clip(input logic [CW-1:0] x);
    logic [CW+OW-1:0] ext;
    ext = {{OW{1'b0}}, x};
    return (ext[CW+OW-1:OW] != '0) ? {OW{1'b1}} : ext[OW-1:0];
  endfunction

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;

  always_comb begin
    logic [7:0] c;
    logic       eof, ws, let_c;
    c         = in_data_byte;
    eof       = in_end_of_file;
    ws        = frp_pkg::is_ws(c);
    let_c     = frp_pkg::is_letter(c);
    phase_nxt = phase_r;
    nl_nxt    = nl_r;
    name_nxt  = name_r;
    cmt_nxt   = cmt_r;
    seq_nxt   = seq_r;
    res_vld   = 1'b0;
    res       = '0;
    res.line  = clip(nl_r);
    unique case (phase_r)
      PH_START: begin
        if (eof || (c != frp_pkg::CH_GT)) begin
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_ERR;
          res.code  = eof ? frp_pkg::E_EMPTY_FILE : frp_pkg::E_NO_GT;
          res.fin   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_NAME;
        end
      end
      PH_NAME: begin
        if (eof) begin
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_ERR;
          res.code  = frp_pkg::E_EOF_NAME;
          res.fin   = 1'b1;
          phase_nxt = PH_DONE;
        end else if (!ws) begin
          name_nxt = sat_inc(name_r);
          res_vld  = 1'b1;
          res.kind = frp_pkg::K_NAME;
          res.data = c;
        end else if (name_r == '0) begin
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_ERR;
          res.code  = frp_pkg::E_EMPTY_NAME;
          res.fin   = 1'b1;
          phase_nxt = PH_DONE;
        end else if (c == frp_pkg::CH_LF) begin
          nl_nxt    = sat_inc(nl_r);
          phase_nxt = PH_SEQ_LEAD;
        end else begin
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_COPEN;
          res.data  = c;
          phase_nxt = PH_COMMENT;
        end
      end
      PH_COMMENT: begin
        if (eof) begin
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_ERR;
          res.code  = frp_pkg::E_EOF_COMMENT;
          res.fin   = 1'b1;
          phase_nxt = PH_DONE;
        end else if (c == frp_pkg::CH_LF) begin
          nl_nxt    = sat_inc(nl_r);
          phase_nxt = PH_SEQ_LEAD;
        end else begin
          cmt_nxt  = sat_inc(cmt_r);
          res_vld  = 1'b1;
          res.kind = frp_pkg::K_CBYTE;
          res.data = c;
        end
      end
      PH_SEQ_LEAD: begin
        if (eof || (!ws && !let_c)) begin
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_ERR;
          res.code  = frp_pkg::E_EMPTY_SEQ;
          res.fin   = 1'b1;
          phase_nxt = PH_DONE;
        end else if (ws) begin
          if (c == frp_pkg::CH_LF) nl_nxt = sat_inc(nl_r);
        end else begin
          seq_nxt   = sat_inc(seq_r);
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_SEQ;
          res.data  = c;
          phase_nxt = PH_SEQ_WORD;
        end
      end
      PH_SEQ_WORD, PH_SEQ_GAP: begin
        if (eof) begin
          res_vld      = 1'b1;
          res.kind     = frp_pkg::K_END;
          res.name_len = clip(name_r);
          res.cmt_len  = clip(cmt_r);
          res.seq_len  = clip(seq_r);
          res.fin      = 1'b1;
          phase_nxt    = PH_DONE;
        end else if (ws) begin
          if (c == frp_pkg::CH_LF) nl_nxt = sat_inc(nl_r);
          phase_nxt = PH_SEQ_GAP;
        end else if ((phase_r == PH_SEQ_WORD) || let_c) begin
          seq_nxt   = sat_inc(seq_r);
          res_vld   = 1'b1;
          res.kind  = frp_pkg::K_SEQ;
          res.data  = c;
          phase_nxt = PH_SEQ_WORD;
        end else begin
          res_vld      = 1'b1;
          res.name_len = clip(name_r);
          res.cmt_len  = clip(cmt_r);
          res.seq_len  = clip(seq_r);
          if (c == frp_pkg::CH_GT) begin
            res.kind  = frp_pkg::K_END;
            name_nxt  = '0;
            cmt_nxt   = '0;
            seq_nxt   = '0;
            phase_nxt = PH_NAME;
          end else begin
            res.kind  = frp_pkg::K_ERR;
            res.code  = frp_pkg::E_EXPECT_GT;
            res.data  = c;
            res.fin   = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      nl_r         <= {{(CW-1){1'b0}}, 1'b1};
      name_r       <= '0;
      cmt_r        <= '0;
      seq_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        nl_r    <= nl_nxt;
        name_r  <= name_nxt;
        cmt_r   <= cmt_nxt;
        seq_r   <= seq_nxt;
      end
      if (skid_valid_r) begin
        if (!out_stall) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (out_free) begin
        out_valid_r <= accept && res_vld;
        if (accept && res_vld) out_r <= res;
      end else if (accept && res_vld) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_r.kind;
  assign out_out_byte = out_r.data;
  assign out_error_code = out_r.code;
  assign out_line_no  = out_r.line;
  assign out_name_len = out_r.name_len;
  assign out_cmt_len  = out_r.cmt_len;
  assign out_seq_len  = out_r.seq_len;
  assign out_finished = out_r.fin;

  `ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `ASSERT_NEXT(a_done_sticks, clk, rst_n, phase_r == PH_DONE, phase_r == PH_DONE)
  `ASSERT_SAME(a_err_finishes, clk, rst_n, out_valid_r && (out_r.kind == frp_pkg::K_ERR), out_r.fin)
  `ASSERT_SAME(a_line_nonzero, clk, rst_n, out_valid_r, out_r.line != '0)

endmodule
